### hw/rtl/fjds_pkg.sv
package fjds_pkg;

    localparam int WORD_W = 32;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic {
        OP_ARRIVE,
        OP_DRAIN
    } opcode_t;

    typedef enum logic [1:0] {
        OUT_DONE,
        OUT_FULL,
        OUT_EXPIRED,
        OUT_OVERRUN
    } outcome_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ARR,
        S_CHECK,
        S_ADV,
        S_EXP,
        S_LATE,
        S_SUM,
        S_OVR,
        S_DLY,
        S_END,
        S_FLUSH
    } state_t;

    typedef struct packed {
        word_t id;
        word_t arrival;
        word_t run;
        word_t deadline;
    } job_entry_t;

    typedef struct packed {
        word_t    id;
        outcome_t outcome;
        word_t    event_time;
        word_t    wait_delay;
        logic     last;
    } rec_t;

    typedef struct packed {
        logic [WORD_W:0] a;
        logic [WORD_W:0] b;
        logic            sub;
    } alu_req_t;

    typedef struct packed {
        logic            borrow;
        logic [WORD_W:0] value;
    } alu_rsp_t;

    typedef struct packed {
        logic       push;
        logic       pop;
        job_entry_t entry;
    } q_ctl_t;

    typedef struct packed {
        logic       empty;
        logic       full;
        logic       one_left;
        job_entry_t front;
    } q_stat_t;

endpackage

### hw/rtl/fjds_if.sv
interface fjds_job_if import fjds_pkg::*; ();
    logic    valid;
    logic    ready;
    opcode_t opcode;
    word_t   job_id;
    word_t   arrival_time;
    word_t   run_length;
    word_t   deadline;

    modport source (
        output valid, opcode, job_id, arrival_time, run_length, deadline,
        input  ready
    );

    modport sink (
        input  valid, opcode, job_id, arrival_time, run_length, deadline,
        output ready
    );
endinterface

interface fjds_result_if import fjds_pkg::*; ();
    logic     valid;
    logic     ready;
    word_t    result_id;
    outcome_t outcome;
    word_t    event_time;
    word_t    wait_delay;
    logic     last_of_run;

    modport source (
        output valid, result_id, outcome, event_time, wait_delay, last_of_run,
        input  ready
    );

    modport sink (
        input  valid, result_id, outcome, event_time, wait_delay, last_of_run,
        output ready
    );
endinterface

### hw/rtl/fjds_alu.sv
module fjds_alu import fjds_pkg::*; (
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [WORD_W+1:0] opa;
    logic [WORD_W+1:0] opb;
    logic [WORD_W+1:0] sum;

    // one adder: subtract as a plus inverted b plus one
    always_comb
    begin
        opa = {1'b0, req.a};
        opb = req.sub ? ~{1'b0, req.b} : {1'b0, req.b};
        sum = opa + opb + {{(WORD_W+1){1'b0}}, req.sub};
        rsp.borrow = sum[WORD_W+1];
        rsp.value  = sum[WORD_W:0];
    end

endmodule

### hw/rtl/fjds_queue.sv
module fjds_queue import fjds_pkg::*; #(
    parameter int QUEUE_DEPTH = 3
) (
    input  logic    clk,
    input  logic    rst_n,
    input  q_ctl_t  ctl,
    output q_stat_t stat
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(QUEUE_DEPTH);

    job_entry_t       mem [QUEUE_DEPTH];
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [SUM_W-1:0] tail_sum;
    logic [IDX_W-1:0] tail;

    always_comb
    begin
        tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
        if (tail_sum >= DEPTH_S)
        begin
            tail_sum = tail_sum - DEPTH_S;
        end
        tail = tail_sum[IDX_W-1:0];

        head_next  = head_reg;
        count_next = count_reg;
        if (ctl.pop)
        begin
            head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + IDX_W'(1);
            count_next = count_reg - CNT_W'(1);
        end
        if (ctl.push)
        begin
            count_next = count_next + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[tail] <= ctl.entry;
        end
    end

    assign stat.empty    = (count_reg == '0);
    assign stat.full     = (count_reg == FULL_CNT);
    assign stat.one_left = (count_reg == CNT_W'(1));
    assign stat.front    = mem[head_reg];

endmodule

### hw/rtl/fjds_ctrl.sv
module fjds_ctrl import fjds_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    fjds_job_if.sink       job,
    fjds_result_if.source  result,
    output alu_req_t alu_req,
    input  alu_rsp_t alu_rsp,
    output q_ctl_t   q_ctl,
    input  q_stat_t  q_stat
);

    state_t          state_reg;
    state_t          state_next;
    opcode_t         op_reg;
    opcode_t         op_next;
    job_entry_t      inc_reg;
    job_entry_t      inc_next;
    word_t           cur_reg;
    word_t           cur_next;
    word_t           free_reg;
    word_t           free_next;
    logic            busy_reg;
    logic            busy_next;
    logic            ovr_reg;
    logic            ovr_next;
    logic [WORD_W:0] fin_reg;
    logic [WORD_W:0] fin_next;
    rec_t            pend_reg;
    rec_t            pend_next;
    logic            pend_valid_reg;
    logic            pend_valid_next;
    rec_t            out_reg;
    rec_t            out_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    logic            out_free;
    logic            emit_ok;
    logic            emit;
    rec_t            emit_rec;
    logic            limited;
    word_t           stop_time;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        inc_next        = inc_reg;
        cur_next        = cur_reg;
        free_next       = free_reg;
        busy_next       = busy_reg;
        ovr_next        = ovr_reg;
        fin_next        = fin_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !result.ready;

        alu_req  = '{a: '0, b: '0, sub: 1'b1};
        q_ctl    = '{push: 1'b0, pop: 1'b0, entry: inc_reg};
        emit     = 1'b0;
        emit_rec = '0;

        out_free  = !out_valid_reg || result.ready;
        emit_ok   = !pend_valid_reg || out_free;
        limited   = (op_reg == OP_ARRIVE);
        stop_time = ovr_reg ? q_stat.front.deadline : fin_reg[WORD_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (job.valid)
                begin
                    op_next  = job.opcode;
                    inc_next = '{id: job.job_id, arrival: job.arrival_time,
                                 run: job.run_length, deadline: job.deadline};
                    state_next = (job.opcode == OP_DRAIN) ? S_CHECK : S_ARR;
                end
            end
            S_ARR:
            begin
                // late arrival is pulled up to the current time
                alu_req.a = {1'b0, inc_reg.arrival};
                alu_req.b = {1'b0, cur_reg};
                if (alu_rsp.borrow)
                begin
                    inc_next.arrival = cur_reg;
                end
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (busy_reg)
                begin
                    if (limited)
                    begin
                        alu_req.a  = {1'b0, inc_reg.arrival};
                        alu_req.b  = {1'b0, free_reg};
                        state_next = alu_rsp.borrow ? S_END : S_ADV;
                    end
                    else
                    begin
                        state_next = q_stat.empty ? S_END : S_ADV;
                    end
                end
                else
                begin
                    state_next = q_stat.empty ? S_END : S_EXP;
                end
            end
            S_ADV:
            begin
                alu_req.a = {1'b0, free_reg};
                alu_req.b = {1'b0, cur_reg};
                if (!alu_rsp.borrow)
                begin
                    cur_next = free_reg;
                end
                busy_next  = 1'b0;
                state_next = S_CHECK;
            end
            S_EXP:
            begin
                alu_req.a  = {1'b0, cur_reg};
                alu_req.b  = {1'b0, q_stat.front.deadline};
                state_next = alu_rsp.borrow ? S_SUM : S_LATE;
            end
            S_LATE:
            begin
                alu_req.a = {1'b0, cur_reg};
                alu_req.b = {1'b0, q_stat.front.arrival};
                if (emit_ok)
                begin
                    emit       = 1'b1;
                    emit_rec   = '{id: q_stat.front.id, outcome: OUT_EXPIRED,
                                   event_time: cur_reg,
                                   wait_delay: alu_rsp.value[WORD_W-1:0], last: 1'b0};
                    q_ctl.pop  = 1'b1;
                    state_next = q_stat.one_left ? S_END : S_EXP;
                end
            end
            S_SUM:
            begin
                alu_req.sub = 1'b0;
                alu_req.a   = {1'b0, cur_reg};
                alu_req.b   = {1'b0, q_stat.front.run};
                fin_next    = alu_rsp.value;
                state_next  = S_OVR;
            end
            S_OVR:
            begin
                alu_req.a  = {1'b0, q_stat.front.deadline};
                alu_req.b  = fin_reg;
                ovr_next   = alu_rsp.borrow;
                state_next = S_DLY;
            end
            S_DLY:
            begin
                alu_req.a = ovr_reg ? {1'b0, q_stat.front.deadline} : {1'b0, cur_reg};
                alu_req.b = {1'b0, q_stat.front.arrival};
                if (emit_ok)
                begin
                    emit       = 1'b1;
                    emit_rec   = '{id: q_stat.front.id,
                                   outcome: ovr_reg ? OUT_OVERRUN : OUT_DONE,
                                   event_time: stop_time,
                                   wait_delay: alu_rsp.value[WORD_W-1:0], last: 1'b0};
                    free_next  = stop_time;
                    busy_next  = 1'b1;
                    q_ctl.pop  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_END:
            begin
                if (limited)
                begin
                    if (!q_stat.full)
                    begin
                        q_ctl.push = 1'b1;
                        cur_next   = inc_reg.arrival;
                        state_next = S_FLUSH;
                    end
                    else if (emit_ok)
                    begin
                        emit       = 1'b1;
                        emit_rec   = '{id: inc_reg.id, outcome: OUT_FULL,
                                       event_time: inc_reg.arrival,
                                       wait_delay: '0, last: 1'b0};
                        cur_next   = inc_reg.arrival;
                        state_next = S_FLUSH;
                    end
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                // held record goes out marked as the last of this item
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_next        = pend_reg;
                    out_next.last   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
        begin
            if (pend_valid_reg)
            begin
                out_next       = pend_reg;
                out_valid_next = 1'b1;
            end
            pend_next       = emit_rec;
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cur_reg        <= '0;
            free_reg       <= '0;
            busy_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_reg        <= cur_next;
            free_reg       <= free_next;
            busy_reg       <= busy_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        inc_reg  <= inc_next;
        ovr_reg  <= ovr_next;
        fin_reg  <= fin_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign job.ready          = (state_reg == S_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.result_id   = out_reg.id;
    assign result.outcome     = out_reg.outcome;
    assign result.event_time  = out_reg.event_time;
    assign result.wait_delay  = out_reg.wait_delay;
    assign result.last_of_run = out_reg.last;

endmodule

### hw/rtl/fifo_job_deadline_scheduler_core.sv
// Single-server job scheduler with a bounded FIFO of waiting jobs and deadline abort.
// Items are taken one at a time: job.ready is high only while the block is idle.
// All time arithmetic runs through one shared 33-bit add/subtract unit, one
// operation per cycle, under a small sequencer. An arrival passes through item
// accept, arrival clamp, server check, enqueue or full report and last-record
// hand-off; a drain takes the same steps without the clamp. Releasing a server
// whose job has finished adds an advance and a recheck. Each queued job dispatched
// on the way adds at most an advance, recheck, expiry test, finish sum, overrun
// test, delay and record, and server check; each job dropped as expired adds an
// expired record and a fresh expiry test. An item also waits while the result
// side holds ready low.
// Results come out one per record, in order, with last_of_run set on the final
// record of each item; an item that causes no record gives no output.
module fifo_job_deadline_scheduler_core import fjds_pkg::*; #(
    parameter int QUEUE_DEPTH = 3
) (
    input  logic          clk,
    input  logic          rst_n,
    fjds_job_if.sink      job,
    fjds_result_if.source result
);

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;
    q_ctl_t   q_ctl;
    q_stat_t  q_stat;

    fjds_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    fjds_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (q_ctl),
        .stat  (q_stat)
    );

    fjds_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .job     (job),
        .result  (result),
        .alu_req (alu_req),
        .alu_rsp (alu_rsp),
        .q_ctl   (q_ctl),
        .q_stat  (q_stat)
    );

endmodule

### hw/rtl/fjds_checker.sv
module fjds_checker import fjds_pkg::*; (
    input logic     clk,
    input logic     rst_n,
    input logic     job_valid,
    input logic     job_ready,
    input logic     result_valid,
    input logic     result_ready,
    input word_t    result_id,
    input outcome_t outcome,
    input word_t    event_time,
    input word_t    wait_delay,
    input logic     last_of_run
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_id)
            && $stable(outcome) && $stable(event_time) && $stable(wait_delay)
            && $stable(last_of_run))
        else $error("result item changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid && job_ready |=> !job_ready)
        else $error("item accepted while previous item still in work");

    a_busy_until_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_of_run |-> !job_ready)
        else $error("ready before the last record of an item");

    a_full_no_delay: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && outcome == OUT_FULL |-> wait_delay == '0)
        else $error("queue full record with nonzero delay");

endmodule

bind fifo_job_deadline_scheduler_core fjds_checker u_fjds_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_valid    (job.valid),
    .job_ready    (job.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_id    (result.result_id),
    .outcome      (result.outcome),
    .event_time   (result.event_time),
    .wait_delay   (result.wait_delay),
    .last_of_run  (result.last_of_run)
);

### tb/fifo_job_deadline_scheduler_core_tb.sv
module fifo_job_deadline_scheduler_core_tb;
    import fjds_pkg::*;

    localparam int QDEPTH      = 3;
    localparam int DIR_N       = 16;
    localparam int RAND_N      = 404;
    localparam int TAIL_N      = 40;
    localparam int QUIET_CYC   = 40;
    localparam int LONG_HOLD   = 300;
    localparam int HOLD_AT     = DIR_N + 100;
    localparam int PAUSE_AT    = DIR_N + 220;
    localparam int STALL_LIMIT = 4000;
    localparam int PRINT_MAX   = 200;

    typedef struct packed {
        opcode_t    op;
        job_entry_t job;
        logic       fixed_want;
        rec_t       want;
    } stim_row_t;

    typedef enum int {
        RX_ALWAYS,
        RX_HALF,
        RX_SPARSE,
        RX_MOSTLY
    } rx_mode_t;

    localparam stim_row_t DIRECTED [DIR_N] = '{
        '{OP_DRAIN,  '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0},
        '{OP_ARRIVE, '{32'd0, 32'd0, 32'd100, 32'hFFFF_FFFF}, 1'b0, '0},
        '{OP_ARRIVE, '{32'hFFFF_FFFF, 32'd0, 32'd1, 32'd50}, 1'b1,
          '{32'd0, OUT_DONE, 32'd100, 32'd0, 1'b1}},
        '{OP_ARRIVE, '{32'd2, 32'd0, 32'd1, 32'd50}, 1'b0, '0},
        '{OP_ARRIVE, '{32'd3, 32'd0, 32'd1, 32'd50}, 1'b0, '0},
        // queue full while the server is busy
        '{OP_ARRIVE, '{32'd4, 32'd0, 32'd1, 32'd50}, 1'b1,
          '{32'd4, OUT_FULL, 32'd0, 32'd0, 1'b1}},
        '{OP_ARRIVE, '{32'd5, 32'd200, 32'd10, 32'd300}, 1'b0, '0},
        // arrival earlier than current time
        '{OP_ARRIVE, '{32'd6, 32'd150, 32'd5, 32'd400}, 1'b0, '0},
        // sum must not wrap in the overrun test
        '{OP_ARRIVE, '{32'd7, 32'd300, 32'hFFFF_FFFF, 32'd1000}, 1'b0, '0},
        '{OP_ARRIVE, '{32'd8, 32'd300, 32'd0, 32'd2000}, 1'b0, '0},
        // deadline before arrival
        '{OP_ARRIVE, '{32'd9, 32'd300, 32'd5, 32'd100}, 1'b0, '0},
        '{OP_ARRIVE, '{32'd10, 32'd1000, 32'd0, 32'hFFFF_FFFF}, 1'b0, '0},
        '{OP_DRAIN,  '{32'd0, 32'd0, 32'd0, 32'd0}, 1'b1,
          '{32'd10, OUT_DONE, 32'd1000, 32'd0, 1'b1}},
        '{OP_DRAIN,  '{32'd0, 32'd0, 32'd0, 32'd0}, 1'b0, '0},
        '{OP_ARRIVE, '{32'hA5A5_A5A5, 32'd2000, 32'h7FFF_FFFF, 32'd5000}, 1'b0, '0},
        '{OP_ARRIVE, '{32'h5A5A_5A5A, 32'd2000, 32'd1, 32'd2001}, 1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n;

    fjds_job_if    job_bus ();
    fjds_result_if result_bus ();

    fifo_job_deadline_scheduler_core #(.QUEUE_DEPTH(QDEPTH)) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .job    (job_bus),
        .result (result_bus)
    );

    // scheduler shadow state
    job_entry_t wait_jobs [QDEPTH];
    int         wait_count  = 0;
    int         wait_head   = 0;
    logic       srv_busy    = 1'b0;
    word_t      srv_free_at = '0;
    word_t      sched_now   = '0;

    rec_t       item_records [$];
    rec_t       pending_records [$];
    stim_row_t  stim_q [$];
    int         jobs_taken = 0;
    int         mismatch_n = 0;
    int         quiet_cyc  = 0;
    rec_t       got_rec;
    rec_t       want_rec;
    string      bad_fields;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic word_t sat_add(word_t a, word_t b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORD_W] ? '1 : s[WORD_W-1:0];
    endfunction

    function automatic void add_record(word_t id, outcome_t oc, word_t at, word_t dly);
        item_records.insert(item_records.size(), rec_t'{id, oc, at, dly, 1'b0});
    endfunction

    function automatic void serve_queue(bit limited, word_t lim);
        word_t           t;
        job_entry_t      e;
        logic [WORD_W:0] finish;
        forever
        begin
            if (srv_busy)
            begin
                if (limited && srv_free_at > lim)
                    break;
                if (!limited && wait_count == 0)
                    break;
                t = (srv_free_at > sched_now) ? srv_free_at : sched_now;
                srv_busy = 1'b0;
                sched_now = t;
            end
            else
                t = sched_now;
            if (wait_count == 0)
                break;
            while (wait_count > 0 && wait_jobs[wait_head].deadline <= t)
            begin
                e = wait_jobs[wait_head];
                add_record(e.id, OUT_EXPIRED, t, t - e.arrival);
                wait_head = (wait_head + 1) % QDEPTH;
                wait_count--;
            end
            if (wait_count == 0)
                continue;
            e = wait_jobs[wait_head];
            finish = {1'b0, t} + {1'b0, e.run};
            if (finish > {1'b0, e.deadline})
            begin
                add_record(e.id, OUT_OVERRUN, e.deadline, e.deadline - e.arrival);
                srv_free_at = e.deadline;
            end
            else
            begin
                add_record(e.id, OUT_DONE, finish[WORD_W-1:0], t - e.arrival);
                srv_free_at = finish[WORD_W-1:0];
            end
            srv_busy = 1'b1;
            wait_head = (wait_head + 1) % QDEPTH;
            wait_count--;
        end
    endfunction

    function automatic void predict_item(opcode_t op, job_entry_t j);
        item_records.delete();
        if (op == OP_DRAIN)
            serve_queue(1'b0, '0);
        else
        begin
            if (j.arrival < sched_now)
                j.arrival = sched_now;
            serve_queue(1'b1, j.arrival);
            sched_now = j.arrival;
            if (wait_count < QDEPTH)
            begin
                wait_jobs[(wait_head + wait_count) % QDEPTH] = j;
                wait_count++;
            end
            else
                add_record(j.id, OUT_FULL, j.arrival, '0);
        end
        if (item_records.size() > 0)
            item_records[item_records.size() - 1].last = 1'b1;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatch_n < PRINT_MAX)
            $display("mismatch: %s", msg);
        mismatch_n++;
    endtask

    task automatic build_random_jobs();
        word_t     base;
        int        made;
        int        burst;
        int        kind;
        stim_row_t row;
        base = 32'd10000;
        made = 0;
        while (made < RAND_N)
        begin
            // last stretch runs at the top of the time range
            if (made >= RAND_N - TAIL_N)
                base = (base < 32'hFFFF_FF00) ? 32'hFFFF_FF00 : base;
            else if ($urandom_range(0, 2) != 0)
                base = sat_add(base, $urandom_range(0, 1 << $urandom_range(4, 22)));
            burst = $urandom_range(1, 7);
            repeat (burst)
            begin
                kind = $urandom_range(0, 99);
                base = sat_add(base, $urandom_range(0, 12));
                row = '0;
                row.op = OP_ARRIVE;
                row.job.id = $urandom();
                row.job.arrival = base;
                row.job.run = $urandom_range(1, 24);
                row.job.deadline = sat_add(base, $urandom_range(0, 70));
                if (kind < 8)
                begin
                    row.op = OP_DRAIN;
                    row.job = {$urandom(), $urandom(), $urandom(), $urandom()};
                end
                else if (kind < 14)
                    row.job.arrival = $urandom_range(0, base);
                else if (kind < 19)
                    row.job.run = $urandom_range(1, 32'hFFFF_FFFF);
                else if (kind < 24)
                    row.job.deadline = $urandom();
                else if (kind < 28)
                    row.job.deadline = base - word_t'($urandom_range(1, 6));
                stim_q.insert(stim_q.size(), row);
                made++;
            end
        end
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending_records.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYC) @(posedge clk);
    endtask

    // prediction on accepted items, checking on accepted records
    always @(posedge clk)
    begin
        if (job_bus.valid && job_bus.ready)
        begin
            predict_item(job_bus.opcode, {job_bus.job_id, job_bus.arrival_time,
                                          job_bus.run_length, job_bus.deadline});
            if (jobs_taken < stim_q.size() && stim_q[jobs_taken].fixed_want)
                pending_records.insert(pending_records.size(), stim_q[jobs_taken].want);
            else
                foreach (item_records[k])
                    pending_records.insert(pending_records.size(), item_records[k]);
            jobs_taken++;
        end
        if (result_bus.valid && result_bus.ready)
        begin
            got_rec = {result_bus.result_id, result_bus.outcome, result_bus.event_time,
                       result_bus.wait_delay, result_bus.last_of_run};
            if (pending_records.size() == 0)
                report_mismatch($sformatf("record for id %h with no job pending", got_rec.id));
            else
            begin
                want_rec = pending_records.pop_front();
                bad_fields = "";
                if (got_rec.id !== want_rec.id)
                    bad_fields = {bad_fields, " result_id"};
                if (got_rec.outcome !== want_rec.outcome)
                    bad_fields = {bad_fields, " outcome"};
                if (got_rec.event_time !== want_rec.event_time)
                    bad_fields = {bad_fields, " event_time"};
                if (got_rec.wait_delay !== want_rec.wait_delay)
                    bad_fields = {bad_fields, " wait_delay"};
                if (got_rec.last !== want_rec.last)
                    bad_fields = {bad_fields, " last_of_run"};
                if (bad_fields != "")
                    report_mismatch($sformatf("%s: got %h/%0d/%h/%h/%b want %h/%0d/%h/%h/%b",
                        bad_fields, got_rec.id, got_rec.outcome, got_rec.event_time,
                        got_rec.wait_delay, got_rec.last, want_rec.id, want_rec.outcome,
                        want_rec.event_time, want_rec.wait_delay, want_rec.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((job_bus.valid && job_bus.ready) || (result_bus.valid && result_bus.ready))
            quiet_cyc <= 0;
        else if (quiet_cyc >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cyc <= quiet_cyc + 1;
    end

    // result side stall pattern
    initial
    begin
        rx_mode_t mode;
        int       span;
        bit       held;
        held = 1'b0;
        result_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            mode = rx_mode_t'($urandom_range(0, 3));
            span = $urandom_range(16, 80);
            repeat (span)
            begin
                @(posedge clk);
                if (!held && jobs_taken >= HOLD_AT)
                begin
                    // long hold so the block backs up into its input
                    held = 1'b1;
                    result_bus.ready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge clk);
                end
                case (mode)
                    RX_ALWAYS: result_bus.ready <= 1'b1;
                    RX_HALF:   result_bus.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: result_bus.ready <= ($urandom_range(0, 7) == 0);
                    default:   result_bus.ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // item sender
    initial
    begin
        int burst;
        int gap;
        int idx;
        job_bus.valid        <= 1'b0;
        job_bus.opcode       <= OP_ARRIVE;
        job_bus.job_id       <= '0;
        job_bus.arrival_time <= '0;
        job_bus.run_length   <= '0;
        job_bus.deadline     <= '0;
        foreach (DIRECTED[r])
            stim_q.insert(stim_q.size(), DIRECTED[r]);
        build_random_jobs();
        wait (rst_n === 1'b1);
        @(posedge clk);
        idx = 0;
        while (idx < stim_q.size())
        begin
            burst = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 12);
            while (burst > 0 && idx < stim_q.size())
            begin
                if (idx == DIR_N || idx == PAUSE_AT)
                begin
                    job_bus.valid <= 1'b0;
                    wait_drained();
                end
                job_bus.valid        <= 1'b1;
                job_bus.opcode       <= stim_q[idx].op;
                job_bus.job_id       <= stim_q[idx].job.id;
                job_bus.arrival_time <= stim_q[idx].job.arrival;
                job_bus.run_length   <= stim_q[idx].job.run;
                job_bus.deadline     <= stim_q[idx].job.deadline;
                do
                    @(posedge clk);
                while (job_bus.ready !== 1'b1);
                idx++;
                burst--;
            end
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                job_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        job_bus.valid <= 1'b0;
        wait_drained();
        if (mismatch_n == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### fifo_job_deadline_scheduler_core.f
hw/rtl/fjds_pkg.sv
hw/rtl/fjds_if.sv
hw/rtl/fjds_alu.sv
hw/rtl/fjds_queue.sv
hw/rtl/fjds_ctrl.sv
hw/rtl/fifo_job_deadline_scheduler_core.sv
hw/rtl/fjds_checker.sv
tb/fifo_job_deadline_scheduler_core_tb.sv
